FILE: hdl/srct_pkg.sv
// Shared types and constants for the slot ring claim tracker.
// No dependencies; used by srct_mod and slot_ring_claim_tracker.
package srct_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int SEQ_W     = 32;
    localparam int CFG_W     = 7;
    localparam logic [CFG_W-1:0] CFG_RST = 7'd64;

    // remainder unit: bits retired per cycle and number of steps
    localparam int MOD_BPC   = 4;
    localparam int MOD_STEPS = SEQ_W / MOD_BPC;

    // register index as decoded from paddr[2]
    localparam logic REG_SLOTS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        OP_CLAIM   = 2'd0,
        OP_PUBLISH = 2'd1,
        OP_FREE    = 2'd2,
        OP_FIND    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_CLAIM,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SEQ_W-1:0] dividend;
        logic [CFG_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } t_mod_rsp;

endpackage

FILE: hdl/srct_mod.sv
// Iterative remainder unit: 32-bit dividend modulo a 7-bit divisor.
// Uses srct_pkg request/response structs; four bits per cycle.
module srct_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srct_pkg::t_mod_req i_req,
    output srct_pkg::t_mod_rsp o_rsp
);

    localparam int CW = $clog2(srct_pkg::MOD_STEPS);

    logic [srct_pkg::SEQ_W-1:0] r_dvd;
    logic [srct_pkg::CFG_W-1:0] r_rem;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [srct_pkg::CFG_W-1:0] w_rem;

    // restoring steps; remainder stays below divisor so one subtract suffices
    always_comb begin
        logic [srct_pkg::CFG_W:0] t;
        w_rem = r_rem;
        t     = '0;
        for (int i = 0; i < srct_pkg::MOD_BPC; i++) begin
            t = {w_rem, r_dvd[srct_pkg::SEQ_W-1-i]};
            if (t >= {1'b0, i_req.divisor}) begin
                t = t - {1'b0, i_req.divisor};
            end
            w_rem = t[srct_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(srct_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << srct_pkg::MOD_BPC;
            r_rem <= w_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: hdl/slot_ring_claim_tracker.sv
// Slot ring claim tracker top: busy/done marks in two 1-bit RAMs, claim counter, APB config.
// Depends on srct_pkg and srct_mod. One word at a time.
// A new word is taken only when idle, after the last result has been loaded into the out register;
// the remainder unit's 8 steps and the one-read-per-cycle done RAM set the pace, and results wait
// in the out register.
// Reset: synchronous active low; then a clearing pass over all SLOTS entries of both RAMs before o_ready rises.
module slot_ring_claim_tracker #(
    parameter int SLOTS = srct_pkg::SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_op,
    input  logic [srct_pkg::SEQ_W-1:0] i_sequence_req,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_success,
    output logic [srct_pkg::SEQ_W-1:0] o_position,
    // APB config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = srct_pkg::CFG_W;
    localparam int SW = srct_pkg::SEQ_W;

    // ---------------------------------------------------------------
    // Config register and effective modulus
    // ---------------------------------------------------------------
    logic [CW-1:0] r_slots;
    logic [CW-1:0] w_mod_n;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == srct_pkg::REG_SLOTS_IN_USE) ? {{(32-CW){1'b0}}, r_slots}
                                                               : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= srct_pkg::CFG_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == srct_pkg::REG_SLOTS_IN_USE) begin
            r_slots <= pwdata[CW-1:0];
        end
    end

    // zero means one slot; anything past SLOTS clamps to SLOTS
    always_comb begin
        if (r_slots == '0) begin
            w_mod_n = CW'(1);
        end else if (32'(r_slots) > SLOTS) begin
            w_mod_n = CW'(SLOTS);
        end else begin
            w_mod_n = r_slots;
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    srct_pkg::t_state r_state, n_state;
    srct_pkg::t_op    r_op, n_op;
    logic [SW-1:0]    r_seq, n_seq;
    logic [SW-1:0]    r_claim_cnt, n_claim_cnt;
    logic [CW-1:0]    r_slot, n_slot;      // slot under work; scan issue pointer
    logic [CW-1:0]    r_chk_k, n_chk_k;    // lap offset whose read data is back
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_res_ok, n_res_ok;
    logic [SW-1:0]    r_res_pos, n_res_pos;
    logic             r_out_valid;
    logic             r_out_ok;
    logic [SW-1:0]    r_out_pos;
    logic             w_out_load;

    // remainder unit
    srct_pkg::t_mod_req w_mod_req;
    srct_pkg::t_mod_rsp w_mod_rsp;

    srct_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // ---------------------------------------------------------------
    // Mark RAMs: one write and one registered read port each
    // ---------------------------------------------------------------
    logic          mem_busy [SLOTS];
    logic          mem_done [SLOTS];
    logic          w_busy_we, w_busy_wdata, w_done_we, w_done_wdata;
    logic [AW-1:0] w_busy_waddr, w_busy_raddr, w_done_waddr, w_done_raddr;
    logic          r_busy_q, r_done_q;

    always_ff @(posedge i_clk) begin
        if (w_busy_we) begin
            mem_busy[w_busy_waddr] <= w_busy_wdata;
        end
        r_busy_q <= mem_busy[w_busy_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_done_we) begin
            mem_done[w_done_waddr] <= w_done_wdata;
        end
        r_done_q <= mem_done[w_done_raddr];
    end

    // ---------------------------------------------------------------
    // Ring step: next slot index, wrapping at the modulus
    // ---------------------------------------------------------------
    logic [CW-1:0] w_wrap_in;
    logic [CW:0]   w_wrap_inc;
    logic [CW-1:0] w_wrap_out;

    assign w_wrap_in  = (r_state == srct_pkg::ST_MOD) ? w_mod_rsp.rem : r_slot;
    assign w_wrap_inc = {1'b0, w_wrap_in} + 1'b1;
    assign w_wrap_out = (w_wrap_inc == {1'b0, w_mod_n}) ? '0 : w_wrap_inc[CW-1:0];

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_seq       = r_seq;
        n_claim_cnt = r_claim_cnt;
        n_slot      = r_slot;
        n_chk_k     = r_chk_k;
        n_clr_addr  = r_clr_addr;
        n_res_ok    = r_res_ok;
        n_res_pos   = r_res_pos;

        w_busy_we    = 1'b0;
        w_busy_wdata = 1'b0;
        w_busy_waddr = AW'(r_slot);
        w_busy_raddr = AW'(r_slot);
        w_done_we    = 1'b0;
        w_done_wdata = 1'b0;
        w_done_waddr = AW'(r_slot);
        w_done_raddr = AW'(r_slot);

        w_mod_req.start    = 1'b0;
        w_mod_req.dividend = r_claim_cnt;
        w_mod_req.divisor  = w_mod_n;

        o_ready    = 1'b0;
        w_out_load = 1'b0;

        case (r_state)
            srct_pkg::ST_CLEAR: begin
                // post-reset sweep, both RAMs one entry per cycle
                w_busy_we    = 1'b1;
                w_done_we    = 1'b1;
                w_busy_waddr = r_clr_addr;
                w_done_waddr = r_clr_addr;
                if (r_clr_addr == AW'(SLOTS - 1)) begin
                    n_state = srct_pkg::ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            srct_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op  = srct_pkg::t_op'(i_op);
                    n_seq = i_sequence_req;
                    w_mod_req.start = 1'b1;
                    if (srct_pkg::t_op'(i_op) != srct_pkg::OP_CLAIM) begin
                        w_mod_req.dividend = i_sequence_req;
                    end
                    n_state = srct_pkg::ST_MOD;
                end
            end
            srct_pkg::ST_MOD: begin
                if (w_mod_rsp.done) begin
                    n_slot    = w_mod_rsp.rem;
                    n_res_ok  = 1'b1;
                    n_res_pos = '0;
                    case (r_op)
                        srct_pkg::OP_CLAIM: begin
                            w_busy_raddr = AW'(w_mod_rsp.rem);
                            n_state      = srct_pkg::ST_CLAIM;
                        end
                        srct_pkg::OP_PUBLISH: begin
                            w_done_we    = 1'b1;
                            w_done_wdata = 1'b1;
                            w_done_waddr = AW'(w_mod_rsp.rem);
                            n_state      = srct_pkg::ST_DONE;
                        end
                        srct_pkg::OP_FREE: begin
                            w_busy_we    = 1'b1;
                            w_done_we    = 1'b1;
                            w_busy_waddr = AW'(w_mod_rsp.rem);
                            w_done_waddr = AW'(w_mod_rsp.rem);
                            n_state      = srct_pkg::ST_DONE;
                        end
                        srct_pkg::OP_FIND: begin
                            // first read now, then one read per cycle
                            w_done_raddr = AW'(w_mod_rsp.rem);
                            n_slot       = w_wrap_out;
                            n_chk_k      = '0;
                            n_state      = srct_pkg::ST_SCAN;
                        end
                        default: begin
                            n_state = srct_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            srct_pkg::ST_CLAIM: begin
                // test and set; counter advances either way
                n_claim_cnt = r_claim_cnt + 1'b1;
                if (!r_busy_q) begin
                    w_busy_we    = 1'b1;
                    w_busy_wdata = 1'b1;
                    n_res_ok     = 1'b1;
                    n_res_pos    = r_claim_cnt;
                end else begin
                    n_res_ok  = 1'b0;
                    n_res_pos = '0;
                end
                n_state = srct_pkg::ST_DONE;
            end
            srct_pkg::ST_SCAN: begin
                // reads past the lap end are issued but never checked
                w_done_raddr = AW'(r_slot);
                n_slot       = w_wrap_out;
                if (r_done_q) begin
                    n_res_ok  = 1'b1;
                    n_res_pos = r_seq + SW'(r_chk_k);
                    n_state   = srct_pkg::ST_DONE;
                end else if (r_chk_k == w_mod_n - 1'b1) begin
                    n_res_ok  = 1'b0;
                    n_res_pos = '0;
                    n_state   = srct_pkg::ST_DONE;
                end else begin
                    n_chk_k = r_chk_k + 1'b1;
                end
            end
            srct_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_state    = srct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srct_pkg::ST_CLEAR;
            r_claim_cnt <= '0;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_claim_cnt <= n_claim_cnt;
            r_clr_addr  <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_seq     <= n_seq;
        r_slot    <= n_slot;
        r_chk_k   <= n_chk_k;
        r_res_ok  <= n_res_ok;
        r_res_pos <= n_res_pos;
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ok  <= r_res_ok;
            r_out_pos <= r_res_pos;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_success  = r_out_ok;
    assign o_position = r_out_pos;

endmodule
